FILE: rtl/core/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

  // Width of every field and register on the ports
  localparam int FIELD_W = 64;

  // Default operand width
  localparam int WIDTH_DEFAULT = 64;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_SQUARE,
    ST_FINISH
  } mexp_state_t;

endpackage

FILE: rtl/core/mexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-and-add with reduction.
`timescale 1ns / 1ps

module mexp_mulmod #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] mult_x,
  input  logic [WIDTH-1:0] mult_y,
  input  logic [WIDTH-1:0] modulus,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] yreg;
  logic [CNT_W-1:0] cnt;

  logic [WIDTH:0]   dbl_sum;
  logic [WIDTH-1:0] dbl_red;
  logic [WIDTH:0]   add_sum;
  logic [WIDTH-1:0] add_red;

  // Double the partial sum, then add the multiplicand where the scanned bit is set
  always_comb begin
    dbl_sum = {1'b0, acc} + {1'b0, acc};
    if (dbl_sum >= {1'b0, modulus}) begin
      dbl_red = WIDTH'(dbl_sum - {1'b0, modulus});
    end else begin
      dbl_red = dbl_sum[WIDTH-1:0];
    end
    add_sum = {1'b0, dbl_red} + {1'b0, mult_x};
    if (add_sum >= {1'b0, modulus}) begin
      add_red = WIDTH'(add_sum - {1'b0, modulus});
    end else begin
      add_red = add_sum[WIDTH-1:0];
    end
    acc_next = yreg[WIDTH-1] ? add_red : dbl_red;
  end

  // Control: load on start, count down the multiplier bits, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial sum and multiplier shift register
  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      yreg <= mult_y;
    end else if (busy) begin
      acc  <= acc_next;
      yreg <= yreg << 1;
    end
  end

  assign product = acc;

endmodule

FILE: rtl/core/modular_exponentiation.sv
// Top level: modular exponentiation by right-to-left square-and-multiply.
//
// Usage:
//   The modulus register is written through cfg_write_enable / cfg_write_data
//   (low WIDTH bits kept) while the block is idle; reset sets it to 1.
//   Input channel in_valid/in_ready carries base_value and exponent_value;
//   output channel out_valid/out_ready carries power_result, base to the
//   exponent mod modulus. One transaction in gives exactly one transaction out.
//   Sequence: the base is first reduced by one modular multiplication, then
//   each exponent bit up to the highest set bit costs one squaring, plus one
//   multiplication for each set bit (the squaring after the top bit is
//   skipped). Each modular multiplication occupies the shared bit-serial
//   multiplier. A modulus of 0 or 1 skips the multiplier and goes straight
//   to the finish state; an exponent of 0 takes only the reduction.
//   in_ready is high only while the sequencer is idle; one item at a time.
//   A finished result sits in the output register; a stalled receiver holds
//   it there, and the next item may be accepted and computed meanwhile, but
//   its result waits until the register is taken.
//   Reset (rst, synchronous) clears the sequencer and drops out_valid.
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [mexp_pkg::FIELD_W-1:0] cfg_write_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mexp_pkg::FIELD_W-1:0] base_value,
  input  logic [mexp_pkg::FIELD_W-1:0] exponent_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mexp_pkg::FIELD_W-1:0] power_result
);

  mexp_pkg::mexp_state_t state;
  mexp_pkg::mexp_state_t state_next;

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] result;
  logic             issue;
  logic             issue_next;

  logic             mul_busy;
  logic             mul_done;
  logic [WIDTH-1:0] mul_x;
  logic [WIDTH-1:0] mul_y;
  logic [WIDTH-1:0] mul_product;

  logic             in_accept;
  logic             out_free;
  logic             mod_trivial;
  logic [WIDTH-1:0] expo_shr;
  logic             op_next;

  assign in_accept   = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign mod_trivial = (modulus <= WIDTH'(1));
  assign expo_shr    = expo >> 1;

  // Shared modular multiplier
  mexp_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (issue),
    .mult_x (mul_x),
    .mult_y (mul_y),
    .modulus(modulus),
    .busy   (mul_busy),
    .done   (mul_done),
    .product(mul_product)
  );

  // Hold the modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(1);
    end else if (cfg_write_enable) begin
      modulus <= cfg_write_data[WIDTH-1:0];
    end
  end

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = mod_trivial ? mexp_pkg::ST_FINISH : mexp_pkg::ST_REDUCE;
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_done) begin
          if (expo == '0) begin
            state_next = mexp_pkg::ST_FINISH;
          end else if (expo[0]) begin
            state_next = mexp_pkg::ST_MULT;
          end else begin
            state_next = mexp_pkg::ST_SQUARE;
          end
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mul_done) begin
          state_next = (expo_shr == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        if (mul_done) begin
          state_next = expo_shr[0] ? mexp_pkg::ST_MULT : mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = mexp_pkg::ST_IDLE;
        end
      end
      default: state_next = mexp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    in_ready = 1'b0;
    mul_x    = sq;
    mul_y    = sq;
    unique case (state)
      mexp_pkg::ST_IDLE:   in_ready = 1'b1;
      mexp_pkg::ST_REDUCE: mul_x = WIDTH'(1);
      mexp_pkg::ST_MULT:   mul_x = acc;
      mexp_pkg::ST_SQUARE: mul_x = sq;
      mexp_pkg::ST_FINISH: in_ready = 1'b0;
      default:             in_ready = 1'b0;
    endcase
  end

  // Launch a multiplication on entry to an arithmetic state or on repeat
  always_comb begin
    op_next    = (state_next == mexp_pkg::ST_REDUCE) ||
                 (state_next == mexp_pkg::ST_MULT)   ||
                 (state_next == mexp_pkg::ST_SQUARE);
    issue_next = op_next && ((state_next != state) || mul_done);
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
      issue <= 1'b0;
    end else begin
      state <= state_next;
      issue <= issue_next;
    end
  end

  // Working registers: accumulator, running square, exponent
  always_ff @(posedge clk) begin
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_accept) begin
          acc  <= mod_trivial ? '0 : WIDTH'(1);
          sq   <= base_value[WIDTH-1:0];
          expo <= exponent_value[WIDTH-1:0];
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_done) begin
          sq <= mul_product;
        end
      end
      mexp_pkg::ST_MULT: begin
        if (mul_done) begin
          acc <= mul_product;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        if (mul_done) begin
          sq   <= mul_product;
          expo <= expo_shr;
        end
      end
      mexp_pkg::ST_FINISH: begin
        acc <= acc;
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Output register: load the finished result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == mexp_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == mexp_pkg::ST_FINISH && out_free) begin
      result <= acc;
    end
  end

  assign power_result = mexp_pkg::FIELD_W'(result);

  // A multiplication is launched only when the unit is free
  assert property (@(posedge clk) disable iff (rst) issue |-> !mul_busy)
    else $error("multiplication launched while unit busy");

  // Completions arrive only while the sequencer waits on one
  assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == mexp_pkg::ST_REDUCE || state == mexp_pkg::ST_MULT ||
                  state == mexp_pkg::ST_SQUARE))
    else $error("multiplier completion outside an arithmetic state");

  // An accepted transaction always leaves the idle state
  assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != mexp_pkg::ST_IDLE)
    else $error("sequencer stayed idle after accepting a transaction");

  // Finishing with a free output slot always presents a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    (state == mexp_pkg::ST_FINISH && out_free) |=> out_valid && state == mexp_pkg::ST_IDLE)
    else $error("finished result not presented");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the modular exponentiation block.
`timescale 1ns / 1ps

module tb;

  localparam int W = mexp_pkg::FIELD_W;
  localparam int LIMIT_CYCLES = 6000000;
  localparam int HOLD_CYCLES = 12000;
  localparam int HOLD_AT = 60;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [W-1:0] MERSENNE_61 = 64'h1FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [W-1:0] base;
    logic [W-1:0] expo;
  } power_req_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_write_enable = 1'b0;
  logic [W-1:0] cfg_write_data = '0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [W-1:0] base_value = '0;
  logic [W-1:0] exponent_value = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] power_result;

  power_req_t   pending_q[$];
  logic [W-1:0] power_expected_q[$];
  logic [W-1:0] active_modulus = 64'd1;
  int unsigned  accepted_cnt = 0;
  int unsigned  result_cnt = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  modulus_writes = 0;
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  modular_exponentiation #(.WIDTH(64)) dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .base_value       (base_value),
    .exponent_value   (exponent_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .power_result     (power_result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // base^expo mod m, right-to-left over all exponent bits, with wide products
  function automatic logic [W-1:0] mod_power(logic [W-1:0] b, logic [W-1:0] e,
                                             logic [W-1:0] m);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] sq;
    logic [2*W-1:0] mw;
    if (m <= 1) return '0;
    mw = {{W{1'b0}}, m};
    acc = (2*W)'(1);
    sq = {{W{1'b0}}, b % m};
    for (int i = 0; i < W; i++) begin
      if (e[i]) acc = (acc * sq) % mw;
      sq = (sq * sq) % mw;
    end
    return acc[W-1:0];
  endfunction

  // Mostly short exponents to keep the run short; some full-width ones
  function automatic power_req_t random_req(logic [W-1:0] m);
    power_req_t  r;
    int unsigned ebits;
    case ($urandom_range(3))
      0: r.base = {$urandom, $urandom};
      1: r.base = (m != 0) ? {$urandom, $urandom} % m : '0;
      2: r.base = W'($urandom_range(16));
      default: r.base = '1 - W'($urandom_range(16));
    endcase
    if ($urandom_range(99) < 15) begin
      r.expo = {$urandom, $urandom};
    end else begin
      ebits = $urandom_range(16, 1);
      r.expo = {$urandom, $urandom} & ((64'd1 << ebits) - 64'd1);
    end
    return r;
  endfunction

  // Track the modulus register as the block sees it
  always @(posedge clk) begin
    if (rst) begin
      active_modulus <= 64'd1;
    end else if (cfg_write_enable) begin
      active_modulus <= cfg_write_data;
    end
  end

  // Driver: predict on acceptance, then offer the next pending transaction
  always @(posedge clk) begin : drive_proc
    power_req_t nxt;
    bit         quiet;
    bit         send;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        power_expected_q.insert(power_expected_q.size(),
                                mod_power(base_value, exponent_value, active_modulus));
        accepted_cnt <= accepted_cnt + 1;
      end
      quiet = (accepted_cnt >= 20) && (accepted_cnt < 45);
      send = (pending_q.size() != 0) && (quiet || $urandom_range(99) >= 9);
      if (in_valid && !in_ready) begin
        // hold the offered transaction until taken
      end else if (send) begin
        nxt = pending_q.pop_front();
        in_valid <= 1'b1;
        base_value <= nxt.base;
        exponent_value <= nxt.expo;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && result_cnt == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin : check_proc
    logic [W-1:0] want;
    bit           quiet;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        result_cnt <= result_cnt + 1;
        if (power_expected_q.size() == 0) begin
          $display("%0t: power_result expected none, actual %h", $time, power_result);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          want = power_expected_q.pop_front();
          if (power_result !== want) begin
            $display("%0t: power_result expected %h, actual %h", $time, want, power_result);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
      quiet = (result_cnt >= 20) && (result_cnt < 45);
      out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 9);
    end
  end

  // Wait until no transaction is queued, offered or outstanding
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || in_valid || power_expected_q.size() != 0);
  endtask

  task automatic write_modulus(logic [W-1:0] v);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    modulus_writes++;
    @(negedge clk);
  endtask

  task automatic add_req(logic [W-1:0] b, logic [W-1:0] e);
    power_req_t r;
    r.base = b;
    r.expo = e;
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_q.insert(pending_q.size(), random_req(active_modulus));
  endtask

  // Stimulus: one phase per modulus setting, drained before each write
  initial begin : stimulus
    logic [W-1:0] rnd_mod;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // modulus of one straight out of reset
    add_req('1, '1);
    add_req(64'd5, 64'd0);
    add_req(64'd0, 64'd0);
    add_req(64'd123, 64'd77);
    queue_random(4);
    wait_drained();

    // full-width modulus: field extremes and bit patterns
    write_modulus('1);
    add_req(64'd0, 64'd0);
    add_req(64'd0, '1);
    add_req('1, '1);
    add_req('1, 64'd1);
    add_req(64'd1, '1);
    add_req(64'd2, 64'd63);
    add_req(64'd2, 64'd64);
    add_req('1 - 64'd1, 64'd2);
    add_req(64'h8000_0000_0000_0000, '1);
    add_req(64'd3, 64'h8000_0000_0000_0000);
    add_req(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    queue_random(25);
    wait_drained();

    // prime modulus: bases below, at and above the modulus
    write_modulus(MERSENNE_61);
    add_req('1, 64'd5);
    add_req(MERSENNE_61, 64'd3);
    add_req(MERSENNE_61 - 64'd1, 64'd2);
    queue_random(35);
    wait_drained();

    write_modulus(64'd2);
    add_req(64'd7, 64'd0);
    add_req(64'd6, 64'd9);
    queue_random(3);
    wait_drained();

    // modulus of one through a register write
    write_modulus(64'd1);
    add_req(64'd9, 64'd4);
    queue_random(3);
    wait_drained();

    rnd_mod = {1'b1, 31'($urandom_range(32'h7FFF_FFFF)), $urandom};
    write_modulus(rnd_mod);
    queue_random(10);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d exponentiations over %0d modulus settings (one, two, full width,",
             accepted_cnt, modulus_writes + 1);
    $display("a 61-bit prime, random), with a long output stall; %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0 && power_expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Abort a hung run
  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule
